[design/bitmap_page_frame_allocator_top_defines.svh]
// Assertion macros for the bitmap page frame allocator checker.
// Expect signals clk and rst_n in the scope of each use.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BPFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define BPFA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/bpfa_pkg.sv]
// Shared types and constants of the bitmap page frame allocator.
// No dependencies.
`default_nettype none

package bpfa_pkg;

  localparam int NUM_PAGES_STORE_DEF = 4096;

  localparam logic [12:0] LIMIT_RESET = 13'd4096;
  localparam logic [12:0] FREE_SAT    = 13'h1FFF;

  localparam logic [1:0] FUNC_GET   = 2'd0;
  localparam logic [1:0] FUNC_ALLOC = 2'd1;
  localparam logic [1:0] FUNC_FREE  = 2'd2;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NOT_FREE = 2'd1;
  localparam logic [1:0] ST_OOM      = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] page_index;
    logic [12:0] page_count;
  } in_word_t;

  typedef struct packed {
    logic [11:0] start_page;
    logic [1:0]  status;
    logic [12:0] free_pages;
  } out_word_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } ctrl_st_t;

endpackage

`default_nettype wire

[design/bpfa_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module bpfa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/bpfa_ctrl.sv]
// Sequencer and page walker: scans, checks, takes and frees runs in the map RAM.
// Depends on bpfa_pkg and bpfa_ram.
`default_nettype none

module bpfa_ctrl #(
  parameter int MAP_DEPTH = bpfa_pkg::NUM_PAGES_STORE_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 req_go,
  input  wire bpfa_pkg::in_word_t   req,
  input  wire logic [12:0]          limit,
  input  wire logic                 res_take,
  output bpfa_pkg::ctrl_st_t        st,
  output bpfa_pkg::out_word_t       res
);

  localparam int AW = $clog2(MAP_DEPTH);
  localparam int FW = AW + 1;
  localparam int PW = (AW + 1 > 14) ? AW + 1 : 14;
  localparam logic [PW-1:0] NP   = PW'(MAP_DEPTH);
  localparam logic [PW-1:0] ONE  = PW'(1);
  localparam logic [AW-1:0] LAST = AW'(MAP_DEPTH - 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_TAKE   = 3'd5;
  localparam logic [2:0] S_FREE   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]    state_r,   state_nxt;
  logic [1:0]    func_r,    func_nxt;
  logic [PW-1:0] idx_r,     idx_nxt;
  logic [PW-1:0] cnt_r,     cnt_nxt;
  logic [PW-1:0] end_r,     end_nxt;
  logic [PW-1:0] rd_addr_r, rd_addr_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic [PW-1:0] pg_r,      pg_nxt;
  logic [PW-1:0] run_r,     run_nxt;
  logic [PW-1:0] wp_r,      wp_nxt;
  logic [PW-1:0] left_r,    left_nxt;
  logic [FW-1:0] fc_r,      fc_nxt;
  logic [11:0]   start_r,   start_nxt;
  logic [1:0]    status_r,  status_nxt;
  logic [AW-1:0] clr_r,     clr_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [0:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [0:0]    ram_rdata;

  logic [PW-1:0] lim;
  logic [PW-1:0] sum;
  logic [PW-1:0] issue_lim;
  logic          issue;
  logic [PW-1:0] run_inc;
  logic [PW-1:0] first;
  logic [PW-1:0] fc_ext;

  bpfa_ram #(
    .WIDTH (1),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign lim       = PW'(limit);
  assign sum       = idx_r + cnt_r;
  assign issue_lim = (state_r == S_SCAN) ? NP : end_r;
  assign issue     = rd_addr_r < issue_lim;
  assign run_inc   = ram_rdata[0] ? run_r + ONE : '0;
  assign first     = pg_r + ONE - cnt_r;
  assign fc_ext    = PW'(fc_r);

  always_comb begin
    state_nxt   = state_r;
    func_nxt    = func_r;
    idx_nxt     = idx_r;
    cnt_nxt     = cnt_r;
    end_nxt     = end_r;
    rd_addr_nxt = rd_addr_r;
    rd_pend_nxt = rd_pend_r;
    pg_nxt      = pg_r;
    run_nxt     = run_r;
    wp_nxt      = wp_r;
    left_nxt    = left_r;
    fc_nxt      = fc_r;
    start_nxt   = start_r;
    status_nxt  = status_r;
    clr_nxt     = clr_r;
    ram_we      = 1'b0;
    ram_waddr   = clr_r;
    ram_wdata   = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = rd_addr_r[AW-1:0];

    unique case (state_r)
      S_CLEAR: begin
        ram_we  = 1'b1;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_go) begin
          func_nxt   = req.func;
          idx_nxt    = PW'(req.page_index);
          cnt_nxt    = PW'(req.page_count);
          start_nxt  = req.page_index;
          status_nxt = bpfa_pkg::ST_DONE;
          state_nxt  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        rd_addr_nxt = idx_r;
        rd_pend_nxt = 1'b0;
        run_nxt     = '0;
        state_nxt   = S_DONE;
        unique case (func_r)
          bpfa_pkg::FUNC_GET: begin
            if (cnt_r == '0) begin
              if (idx_r >= lim) begin
                status_nxt = bpfa_pkg::ST_OOM;
              end
            end else if (idx_r >= NP) begin
              status_nxt = bpfa_pkg::ST_OOM;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          bpfa_pkg::FUNC_ALLOC: begin
            if (idx_r > NP || cnt_r > NP - idx_r) begin
              status_nxt = bpfa_pkg::ST_NOT_FREE;
            end else if (cnt_r != '0) begin
              end_nxt   = sum;
              state_nxt = S_CHECK;
            end
          end
          bpfa_pkg::FUNC_FREE: begin
            end_nxt = (sum < NP) ? sum : NP;
            if (idx_r < ((sum < NP) ? sum : NP)) begin
              state_nxt = S_FREE;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        ram_re = issue;
        if (issue) begin
          rd_addr_nxt = rd_addr_r + ONE;
          pg_nxt      = rd_addr_r;
        end
        rd_pend_nxt = issue;
        if (rd_pend_r) begin
          run_nxt = run_inc;
        end
        priority if (rd_pend_r && run_inc == cnt_r) begin
          rd_pend_nxt = 1'b0;
          if (first < lim) begin
            start_nxt = first[11:0];
            wp_nxt    = first;
            left_nxt  = cnt_r;
            fc_nxt    = fc_r - cnt_r[FW-1:0];
            state_nxt = S_TAKE;
          end else begin
            status_nxt = bpfa_pkg::ST_OOM;
            state_nxt  = S_DONE;
          end
        end else if (!rd_pend_r && !issue) begin
          status_nxt = bpfa_pkg::ST_OOM;
          state_nxt  = S_DONE;
        end
      end
      S_CHECK: begin
        ram_re = issue;
        if (issue) begin
          rd_addr_nxt = rd_addr_r + ONE;
          pg_nxt      = rd_addr_r;
        end
        rd_pend_nxt = issue;
        if (rd_pend_r) begin
          priority if (!ram_rdata[0]) begin
            rd_pend_nxt = 1'b0;
            status_nxt  = bpfa_pkg::ST_NOT_FREE;
            state_nxt   = S_DONE;
          end else if (pg_r == end_r - ONE) begin
            rd_pend_nxt = 1'b0;
            wp_nxt      = idx_r;
            left_nxt    = cnt_r;
            fc_nxt      = fc_r - cnt_r[FW-1:0];
            state_nxt   = S_TAKE;
          end
        end
      end
      S_TAKE: begin
        ram_we    = 1'b1;
        ram_waddr = wp_r[AW-1:0];
        ram_wdata = 1'b0;
        wp_nxt    = wp_r + ONE;
        left_nxt  = left_r - ONE;
        if (left_r == ONE) begin
          state_nxt = S_DONE;
        end
      end
      S_FREE: begin
        ram_re = issue;
        if (issue) begin
          rd_addr_nxt = rd_addr_r + ONE;
          pg_nxt      = rd_addr_r;
        end
        rd_pend_nxt = issue;
        if (rd_pend_r) begin
          if (!ram_rdata[0]) begin
            ram_we    = 1'b1;
            ram_waddr = pg_r[AW-1:0];
            ram_wdata = 1'b1;
            fc_nxt    = fc_r + FW'(1);
          end
          if (pg_r == end_r - ONE) begin
            rd_pend_nxt = 1'b0;
            state_nxt   = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      rd_pend_r <= 1'b0;
      fc_r      <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      rd_pend_r <= rd_pend_nxt;
      fc_r      <= fc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    idx_r     <= idx_nxt;
    cnt_r     <= cnt_nxt;
    end_r     <= end_nxt;
    rd_addr_r <= rd_addr_nxt;
    pg_r      <= pg_nxt;
    run_r     <= run_nxt;
    wp_r      <= wp_nxt;
    left_r    <= left_nxt;
    start_r   <= start_nxt;
    status_r  <= status_nxt;
  end

  assign st.idle      = (state_r == S_IDLE);
  assign st.res_valid = (state_r == S_DONE);

  assign res.start_page = start_r;
  assign res.status     = status_r;
  assign res.free_pages = (fc_ext > PW'(bpfa_pkg::FREE_SAT)) ? bpfa_pkg::FREE_SAT
                                                               : fc_ext[12:0];

endmodule

`default_nettype wire

[design/bitmap_page_frame_allocator_top.sv]
// Top level of the bitmap page frame allocator: limit register, output register.
// Depends on bpfa_pkg and bpfa_ctrl.
//
//   port group | dir | handshake             | word
//   in_        | in  | in_valid / in_stall   | bpfa_pkg::in_word_t
//   out_       | out | out_valid / out_stall | bpfa_pkg::out_word_t
//   cfg_       | in  | cfg_valid / cfg_ready | limit_pages, 13 bits
//
// One page of the map RAM is read per cycle: get scans pages from page_index until
// it finds a free run of page_count, then takes it; alloc-at checks the run at
// page_index, then takes it; free reads each page of the run and marks it free.
// After reset a clearing pass writes every page of the map RAM; in_stall stays high.
// A result waiting under out_stall holds the sequencer before it returns to idle.
`default_nettype none

module bitmap_page_frame_allocator_top #(
  parameter int NUM_PAGES_STORE = bpfa_pkg::NUM_PAGES_STORE_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire bpfa_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output bpfa_pkg::out_word_t      out_word,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [12:0]         cfg_data
);

  bpfa_pkg::ctrl_st_t  ctrl_st;
  bpfa_pkg::out_word_t res;
  logic                req_go;
  logic                res_take;

  logic [12:0]         limit_r,     limit_nxt;
  logic                out_valid_r, out_valid_nxt;
  bpfa_pkg::out_word_t out_word_r,  out_word_nxt;

  bpfa_ctrl #(
    .MAP_DEPTH (NUM_PAGES_STORE)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_go   (req_go),
    .req      (in_word),
    .limit    (limit_r),
    .res_take (res_take),
    .st       (ctrl_st),
    .res      (res)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = !ctrl_st.idle;
  assign req_go    = in_valid && !in_stall;
  assign res_take  = !out_valid_r || !out_stall;

  always_comb begin
    limit_nxt     = limit_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (cfg_valid && cfg_ready) begin
      limit_nxt = cfg_data;
    end
    if (ctrl_st.res_valid && res_take) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= bpfa_pkg::LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

[design/bpfa_chk.sv]
// Port-level checker for the bitmap page frame allocator, bound to the top level.
// Depends on bpfa_pkg and bitmap_page_frame_allocator_top_defines.svh.
`default_nettype none
`include "bitmap_page_frame_allocator_top_defines.svh"

module bpfa_chk (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire bpfa_pkg::out_word_t out_word
);

  `BPFA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "out word dropped under stall")
  `BPFA_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_word), "stalled word changed")
  `BPFA_ASSERT_NXT(a_busy_after_take, in_valid && !in_stall, in_stall, "new word taken while busy")
  `BPFA_ASSERT_IMP(a_clear_after_reset, !$past(rst_n), in_stall && !out_valid, "clear skipped")

endmodule

bind bitmap_page_frame_allocator_top bpfa_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

`default_nettype wire
